>>> rtl/dshqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshqp_pkg
// Shared types and constants for the digit-sum hash table with quadratic
// probing.
// ----------------------------------------------------------------------------
package dshqp_pkg;

  localparam int KEY_W      = 27;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 7;
  localparam int COUNT_W    = 16;
  localparam int LIMIT_W    = 7;
  localparam int SUM_W      = 7;   // digit sum of eight digits is at most 72
  localparam int DIGIT_W    = 4;

  localparam int TABLE_SIZE_DEF = 128;
  localparam int KEY_DIGITS_DEF = 8;

  localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RST = 7'd99;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

  // floor(x / 10) = (x * MAGIC) >> 31, exact for x < 2**30
  localparam int                       MAGIC_W     = 28;
  localparam int                       PROD_W      = KEY_W + MAGIC_W;
  localparam int                       DIV_SHIFT   = 31;
  localparam logic [MAGIC_W-1:0]       DIV10_MAGIC = 28'hCCCCCCD;

  // request modes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HOME      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PROBED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                collided;
    logic [COUNT_W-1:0]  collision_total;
  } rsp_t;

  // handshake between sequencer and digit-sum unit
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } dsum_cmd_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
  } dsum_rsp_t;

endpackage

>>> rtl/dshqp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshqp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module dshqp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dshqp_digsum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshqp_digsum
// Iterative decimal digit sum: one digit per cycle through a shared
// divide-by-ten (reciprocal multiply) unit.
// ----------------------------------------------------------------------------
module dshqp_digsum #(
  parameter int KEY_DIGITS = dshqp_pkg::KEY_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dshqp_pkg::dsum_cmd_t  cmd,
  output dshqp_pkg::dsum_rsp_t  rsp
);

  localparam int CNT_W = $clog2(KEY_DIGITS + 1);

  logic                             run;
  logic [CNT_W-1:0]                 cnt;
  logic [dshqp_pkg::KEY_W-1:0]      rem;
  logic [dshqp_pkg::SUM_W-1:0]      acc;
  logic                             done;

  logic [dshqp_pkg::PROD_W-1:0]     prod;
  logic [dshqp_pkg::KEY_W-1:0]      quo;
  logic [dshqp_pkg::KEY_W-1:0]      quo_x10;
  logic [dshqp_pkg::KEY_W-1:0]      diff;
  logic [dshqp_pkg::DIGIT_W-1:0]    digit;

  assign prod    = dshqp_pkg::PROD_W'(rem) * dshqp_pkg::PROD_W'(dshqp_pkg::DIV10_MAGIC);
  assign quo     = dshqp_pkg::KEY_W'(prod >> dshqp_pkg::DIV_SHIFT);
  assign quo_x10 = (quo << 3) + (quo << 1);
  assign diff    = rem - quo_x10;
  assign digit   = diff[dshqp_pkg::DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (cmd.start) begin
        run  <= 1'b1;
        cnt  <= '0;
        rem  <= cmd.key;
        acc  <= '0;
        done <= 1'b0;
      end else if (run) begin
        rem <= quo;
        acc <= acc + dshqp_pkg::SUM_W'(digit);
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(KEY_DIGITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.sum  = acc;

endmodule

>>> rtl/digit_sum_hash_quadratic_probe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digit_sum_hash_quadratic_probe
// Open-addressed hash table of decimal keys. Home slot is the key's digit
// sum; collisions probe home + i*i modulo the table size.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction | item
//  --------+---------------------------------+-----------+--------------------
//  req     | req_valid, req_stall, req       | in        | mode, key
//  rsp     | rsp_valid, rsp_stall, rsp       | out       | status, slot,
//          |                                 |           | collided, total
//  cfg     | cfg_wr_en, cfg_wr_data          | in        | probe_limit
//
//  Insert / lookup: the digit sum is formed first, then each probe takes a
//  RAM read and a compare, and S_DONE loads the result register.
//  Clear: one RAM entry written per cycle, then the result register is loaded.
//  After reset a clearing pass over the whole table runs before req is taken.
//  req_stall is high while an item is in work; a finished result waits in
//  the rsp register, and the next item can be taken while it waits.
// ----------------------------------------------------------------------------
module digit_sum_hash_quadratic_probe #(
  parameter int TABLE_SIZE = dshqp_pkg::TABLE_SIZE_DEF,
  parameter int KEY_DIGITS = dshqp_pkg::KEY_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [dshqp_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  dshqp_pkg::req_t                 req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output dshqp_pkg::rsp_t                 rsp
);

  localparam int AW    = $clog2(TABLE_SIZE);
  localparam int ENT_W = dshqp_pkg::KEY_W + 1;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHK   = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                          state;
  logic [dshqp_pkg::MODE_W-1:0]    op;
  logic [dshqp_pkg::KEY_W-1:0]     key_r;
  logic [AW-1:0]                   pos;
  logic [AW-1:0]                   step;
  logic [dshqp_pkg::LIMIT_W-1:0]   idx;
  logic [AW-1:0]                   sweep;
  logic [dshqp_pkg::LIMIT_W-1:0]   probe_limit;
  logic [dshqp_pkg::COUNT_W-1:0]   coll_cnt;
  logic [dshqp_pkg::STATUS_W-1:0]  res_status;
  logic [dshqp_pkg::SLOT_W-1:0]    res_slot;
  logic                            res_collided;

  dshqp_pkg::dsum_cmd_t            dsum_cmd;
  dshqp_pkg::dsum_rsp_t            dsum_rsp;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [ENT_W-1:0]                ram_wdata;
  logic [ENT_W-1:0]                ram_rdata;
  logic                            rd_used;
  logic [dshqp_pkg::KEY_W-1:0]     rd_key;

  logic                            req_take;
  logic                            is_insert;
  logic                            at_limit;
  logic                            sweep_last;
  logic                            rsp_free;
  logic [AW:0]                     pos_sum;
  logic [AW-1:0]                   pos_next;
  logic [AW:0]                     step_sum;
  logic [AW-1:0]                   step_next;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign is_insert  = (op == dshqp_pkg::MODE_INSERT);
  assign at_limit   = (idx == probe_limit);
  assign sweep_last = (sweep == AW'(TABLE_SIZE - 1));

  assign rd_used = ram_rdata[ENT_W-1];
  assign rd_key  = ram_rdata[dshqp_pkg::KEY_W-1:0];

  // next probe: pos += step, step += 2, both kept below TABLE_SIZE
  assign pos_sum   = {1'b0, pos} + {1'b0, step};
  assign pos_next  = (pos_sum >= (AW+1)'(TABLE_SIZE)) ?
                     AW'(pos_sum - (AW+1)'(TABLE_SIZE)) : AW'(pos_sum);
  assign step_sum  = {1'b0, step} + (AW+1)'(2);
  assign step_next = (step_sum >= (AW+1)'(TABLE_SIZE)) ?
                     AW'(step_sum - (AW+1)'(TABLE_SIZE)) : AW'(step_sum);

  assign dsum_cmd.start = req_take && (req.mode != dshqp_pkg::MODE_CLEAR);
  assign dsum_cmd.key   = req.key;

  dshqp_digsum #(
    .KEY_DIGITS (KEY_DIGITS)
  ) u_digsum (
    .clk (clk),
    .rst (rst),
    .cmd (dsum_cmd),
    .rsp (dsum_rsp)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep;
    ram_wdata = '0;
    case (state)
      S_INIT, S_SWEEP: begin
        ram_we = 1'b1;
      end
      S_CHK: begin
        if (is_insert && !rd_used) begin
          ram_we    = 1'b1;
          ram_waddr = pos;
          ram_wdata = {1'b1, key_r};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  dshqp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep       <= '0;
      probe_limit <= dshqp_pkg::PROBE_LIMIT_RST;
      coll_cnt    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        probe_limit <= cfg_wr_data;
      end
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_INIT: begin
          sweep <= sweep_last ? '0 : sweep + 1'b1;
          if (sweep_last) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req_take) begin
            op           <= req.mode;
            key_r        <= req.key;
            res_status   <= dshqp_pkg::ST_NOT_FOUND;
            res_slot     <= '0;
            res_collided <= 1'b0;
            if (req.mode == dshqp_pkg::MODE_CLEAR) begin
              state <= S_SWEEP;
            end else begin
              state <= S_HASH;
            end
          end
        end

        S_HASH: begin
          if (dsum_rsp.done) begin
            // digit sum never reaches TABLE_SIZE, so it is the home slot
            pos   <= AW'(dsum_rsp.sum);
            step  <= AW'(1);
            idx   <= '0;
            state <= S_READ;
          end
        end

        S_READ: begin
          state <= S_CHK;
        end

        S_CHK: begin
          if (is_insert) begin
            if (!rd_used) begin
              res_status <= (idx == '0) ? dshqp_pkg::ST_HOME : dshqp_pkg::ST_PROBED;
              res_slot   <= pos[dshqp_pkg::SLOT_W-1:0];
              state      <= S_DONE;
            end else begin
              if (idx == '0) begin
                res_collided <= 1'b1;
                if (coll_cnt != dshqp_pkg::COUNT_MAX) begin
                  coll_cnt <= coll_cnt + 1'b1;
                end
              end
              if (at_limit) begin
                res_status <= dshqp_pkg::ST_FULL;
                res_slot   <= '0;
                state      <= S_DONE;
              end else begin
                idx   <= idx + 1'b1;
                pos   <= pos_next;
                step  <= step_next;
                state <= S_READ;
              end
            end
          end else begin
            if (!rd_used) begin
              state <= S_DONE;
            end else if (rd_key == key_r) begin
              res_status <= dshqp_pkg::ST_FOUND;
              res_slot   <= pos[dshqp_pkg::SLOT_W-1:0];
              state      <= S_DONE;
            end else if (at_limit) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              pos   <= pos_next;
              step  <= step_next;
              state <= S_READ;
            end
          end
        end

        S_SWEEP: begin
          sweep <= sweep_last ? '0 : sweep + 1'b1;
          if (sweep_last) begin
            coll_cnt   <= '0;
            res_status <= dshqp_pkg::ST_CLEARED;
            state      <= S_DONE;
          end
        end

        S_DONE: begin
          if (rsp_free) begin
            rsp.status          <= res_status;
            rsp.slot            <= res_slot;
            rsp.collided        <= res_collided;
            rsp.collision_total <= coll_cnt;
            state               <= S_IDLE;
          end
        end

        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // no table write while waiting for an item
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("table write while idle");

  // an accepted item makes the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_take |=> req_stall)
    else $error("request taken but block not busy");

  // the counter only drops at the end of a clear
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state != S_SWEEP) |=> (coll_cnt >= $past(coll_cnt)))
    else $error("collision count dropped outside a clear");

  // the result register is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_valid && rsp_stall) |=> (state == S_DONE))
    else $error("result left done state while output stalled");
`endif

endmodule
